/* rtl/length_prefixed_packet_deframer_defines.svh */
// Assertion macros shared by the deframer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked only outside reset.
`define LPPD_ASSERT_ON(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lppd assertion failed")
// Property checked at every edge, reset included.
`define LPPD_ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lppd assertion failed")
`else
`define LPPD_ASSERT_ON(lbl, clk, rstn, prop)
`define LPPD_ASSERT_ALL(lbl, clk, prop)
`endif
`endif

/* rtl/lppd_pkg.sv */
// Shared constants and the result record of the packet deframer.
// No dependencies; imported by every deframer module.
package lppd_pkg;

    localparam int unsigned HEADER_BYTES = 7;
    localparam int unsigned LENGTH_BYTES = 4;
    localparam logic [15:0] LENGTH_LIMIT = 16'hFFFF;
    localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        has_byte;
        logic        is_last;
        logic [15:0] seq_number;
        logic [7:0]  packet_type;
        logic [31:0] session_token;
        logic [15:0] body_length;
        logic        bad_length;
    } t_result;

endpackage

/* rtl/lppd_parse.sv */
// Input word register, framing state machine and header capture.
// Depends on lppd_pkg and the assertion macro header.
`include "length_prefixed_packet_deframer_defines.svh"

module lppd_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output logic              o_ready,
    input  logic              i_cfg_wr,
    input  logic [15:0]       i_cfg_data,
    output logic              o_res_valid,
    output lppd_pkg::t_result o_res,
    input  logic              i_res_ready
);
    import lppd_pkg::*;

    typedef enum logic [0:0] {
        PH_LENGTH,
        PH_BODY
    } t_phase;

    localparam logic [15:0] LEN_LAST_POS = 16'(LENGTH_BYTES - 1);
    localparam logic [15:0] SEQ_END_POS  = 16'd2;
    localparam logic [15:0] TYPE_POS     = 16'd2;
    localparam logic [15:0] HDR_END_POS  = 16'(HEADER_BYTES);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [15:0] r_max;
    t_phase      r_phase, n_phase;
    logic [15:0] r_cnt, n_cnt;
    logic [31:0] r_len, n_len;
    logic [15:0] r_seq, n_seq;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_token, n_token;

    logic        emit;
    t_result     res;
    logic [31:0] len_shift;
    logic        len_bad;
    logic        body_last;
    logic        go;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_seq     = r_seq;
        n_type    = r_type;
        n_token   = r_token;
        emit      = 1'b0;
        res       = '0;
        len_shift = {r_len[23:0], r_in_byte};
        len_bad   = (len_shift < 32'(HEADER_BYTES)) || (len_shift > {16'd0, r_max});
        body_last = ({1'b0, r_cnt} + 17'd1) == {1'b0, r_len[15:0]};
        case (r_phase)
            PH_BODY: begin
                res.seq_number    = r_seq;
                res.packet_type   = r_type;
                res.session_token = r_token;
                res.body_length   = r_len[15:0];
                res.is_last       = body_last;
                if (r_cnt < SEQ_END_POS) begin
                    n_seq = {r_seq[7:0], r_in_byte};
                end else if (r_cnt == TYPE_POS) begin
                    n_type = r_in_byte;
                end else if (r_cnt < HDR_END_POS) begin
                    n_token = {r_token[23:0], r_in_byte};
                    // A body that is only a header still reports its fields once.
                    res.session_token = {r_token[23:0], r_in_byte};
                    emit = body_last;
                end else begin
                    res.payload_byte = r_in_byte;
                    res.has_byte     = 1'b1;
                    emit             = 1'b1;
                end
                if (body_last) begin
                    n_phase = PH_LENGTH;
                    n_cnt   = '0;
                    n_len   = '0;
                end else begin
                    n_cnt = r_cnt + 16'd1;
                end
            end
            default: begin
                n_len = len_shift;
                if (r_cnt == LEN_LAST_POS) begin
                    n_cnt = '0;
                    if (len_bad) begin
                        emit            = 1'b1;
                        res.bad_length  = 1'b1;
                        res.body_length = (len_shift[31:16] != 16'd0) ?
                                          LENGTH_LIMIT : len_shift[15:0];
                        n_len           = '0;
                    end else begin
                        n_phase = PH_BODY;
                        n_seq   = '0;
                        n_type  = '0;
                        n_token = '0;
                    end
                end else begin
                    n_cnt = r_cnt + 16'd1;
                end
            end
        endcase
    end

    // A word that makes no result never waits on the output side.
    assign go          = r_in_valid && (!emit || i_res_ready);
    assign o_ready     = !r_in_valid || go;
    assign o_res_valid = go && emit;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_max      <= MAX_LEN_RESET;
            r_phase    <= PH_LENGTH;
            r_cnt      <= '0;
            r_len      <= '0;
            r_seq      <= '0;
            r_type     <= '0;
            r_token    <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (i_cfg_wr) begin
                r_max <= i_cfg_data;
            end
            if (go) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_len   <= n_len;
                r_seq   <= n_seq;
                r_type  <= n_type;
                r_token <= n_token;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_byte <= i_byte;
        end
    end

    `LPPD_ASSERT_ON(a_len_count, i_clk, i_rst_n, (r_phase == PH_LENGTH) |-> (r_cnt < 16'(LENGTH_BYTES)));
    `LPPD_ASSERT_ON(a_body_len_ok, i_clk, i_rst_n, (r_phase == PH_BODY) |-> ((r_len[31:16] == 16'd0) && (r_len[15:0] >= 16'(HEADER_BYTES))));
    `LPPD_ASSERT_ON(a_body_pos, i_clk, i_rst_n, (r_phase == PH_BODY) |-> (r_cnt < r_len[15:0]));
    `LPPD_ASSERT_ON(a_bad_shape, i_clk, i_rst_n, (o_res_valid && o_res.bad_length) |-> (!o_res.has_byte && !o_res.is_last && (r_phase == PH_LENGTH)));

endmodule

/* rtl/lppd_outreg.sv */
// Result register between the framing logic and the output stream.
// Depends on lppd_pkg and the assertion macro header.
`include "length_prefixed_packet_deframer_defines.svh"

module lppd_outreg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lppd_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    output lppd_pkg::t_result o_res,
    input  logic              i_ready
);
    import lppd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    `LPPD_ASSERT_ALL(a_rst_empty, i_clk, !i_rst_n |=> !r_valid);
    `LPPD_ASSERT_ON(a_empty_ready, i_clk, i_rst_n, !r_valid |-> o_ready);
    `LPPD_ASSERT_ON(a_full_hold, i_clk, i_rst_n, (r_valid && !i_ready) |-> !o_ready);

endmodule

/* rtl/length_prefixed_packet_deframer.sv */
// Length-prefixed packet deframer: stream byte input, per-byte result output.
// Depends on lppd_pkg, lppd_parse and lppd_outreg.
//
// Usage: the slave stream carries one received byte per word in s_axis_tdata.
// Each packet is a 32-bit big-endian body length followed by the body; the
// body begins with a 16-bit sequence number, an 8-bit type and a 32-bit token,
// and the rest is payload. Every payload byte leaves as one master-stream word
// with the header fields and body length beside it; m_axis_tlast marks the
// final word of a packet. A body with no payload gives one word without a
// byte. A length below seven or above the configured maximum gives one word
// with the bad-length flag set, and framing restarts at the next byte.
// The configuration channel writes the maximum body length; it is always
// ready and should only be written while the stream is idle.
// An accepted byte is held in the input word register and framed from there
// by the combinational state machine; its word is then loaded into the
// result register, whose valid flag drives m_axis_tvalid.
// One byte is taken every cycle, set by the single pass through the framing
// state machine between the input word register and the result register.
// When the receiver stalls, the result register holds its word; bytes that
// make no word still pass, but the first byte that makes a word waits in the
// input register and s_axis_tready drops until the result register drains.
// Reset (synchronous, active low) empties both registers, returns framing to
// the length field and sets the maximum body length to 65535.

module length_prefixed_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // max_body_length
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] seq_number,
                                        // [31:24] packet_type, [63:32] session_token,
                                        // [79:64] body_length
    output logic [1:0]  m_axis_tuser,   // [0] has_byte, [1] bad_length
    output logic        m_axis_tlast    // is_last
);
    import lppd_pkg::*;

    logic    res_valid;
    logic    res_ready;
    t_result res;
    t_result out_res;

    // The maximum is a plain register, so a write always lands at once.
    assign o_cfg_ready = 1'b1;

    lppd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .o_ready     (s_axis_tready),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    lppd_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (res_ready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (m_axis_tready)
    );

    // Pack the result word, first field in the lowest bits.
    assign m_axis_tdata = {out_res.body_length, out_res.session_token,
                           out_res.packet_type, out_res.seq_number,
                           out_res.payload_byte};
    assign m_axis_tuser = {out_res.bad_length, out_res.has_byte};
    assign m_axis_tlast = out_res.is_last;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for length_prefixed_packet_deframer: a directed table of
// framing corner cases, then random packet streams checked against a local deframer model.
// Depends on lppd_pkg and the deframer RTL only.
`timescale 1ns / 100ps

module tb_top;
    import lppd_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;      // well past the path through the input and result registers
    localparam int PHASE_COUNT   = 9;

    // Framing phases of the local model; codes two and three never occur.
    typedef enum logic [1:0] {
        FR_LENGTH = 2'd0,
        FR_BODY   = 2'd1
    } t_frame_phase;

    // One row of the directed table: a stream byte and, where it is obvious,
    // the result word that this byte must produce.
    typedef struct {
        logic [7:0] data;
        bit         has_want;
        t_result    want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 16'h0000;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    length_prefixed_packet_deframer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 4 ns clock period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Model state of the deframer. It mirrors the framing registers of the block
    // and is advanced once for every byte that the block accepts.
    t_frame_phase fr_phase = FR_LENGTH;
    logic [15:0]  fr_count = '0;
    logic [31:0]  fr_len   = '0;
    logic [15:0]  fr_seq   = '0;
    logic [7:0]   fr_type  = '0;
    logic [31:0]  fr_token = '0;
    logic [15:0]  max_len  = MAX_LEN_RESET;

    t_result    pending_results[$];    // result words still owed by the block
    logic [7:0] stream_bytes[$];       // generated stream not yet sent
    int         burst_left = 0;
    int         mismatch_count = 0;

    function automatic t_result make_result(input logic [7:0] pb, input logic hb,
                                            input logic last, input logic [15:0] seq,
                                            input logic [7:0] typ, input logic [31:0] tok,
                                            input logic [15:0] blen, input logic bad);
        t_result r;
        r.payload_byte  = pb;
        r.has_byte      = hb;
        r.is_last       = last;
        r.seq_number    = seq;
        r.packet_type   = typ;
        r.session_token = tok;
        r.body_length   = blen;
        r.bad_length    = bad;
        return r;
    endfunction

    // Advances the model by one stream byte. Returns 1 and fills r when the byte
    // produces a result word.
    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        logic [15:0] pos;
        bit          last;
        bit          produced;
        r = '0;
        produced = 1'b0;
        if (fr_phase != FR_BODY) begin
            // Length field: four bytes, most significant first.
            fr_len   = {fr_len[23:0], b};
            fr_count = fr_count + 16'd1;
            if (fr_count < LENGTH_BYTES) begin
                fr_phase = FR_LENGTH;
                return 1'b0;
            end
            fr_count = '0;
            if (fr_len < HEADER_BYTES || fr_len > {16'h0000, max_len}) begin
                // Rejected length: the reported length saturates at 16 bits and
                // framing restarts with the very next byte.
                r = make_result(8'h00, 1'b0, 1'b0, 16'h0000, 8'h00, 32'h0,
                                (fr_len > {16'h0000, LENGTH_LIMIT}) ? LENGTH_LIMIT
                                                                    : fr_len[15:0],
                                1'b1);
                fr_phase = FR_LENGTH;
                fr_len   = '0;
                return 1'b1;
            end
            fr_phase = FR_BODY;
            fr_seq   = '0;
            fr_type  = '0;
            fr_token = '0;
            return 1'b0;
        end

        pos  = fr_count;
        last = ({16'h0000, pos} + 32'd1 == fr_len);
        if (pos < 16'd2) begin
            fr_seq = {fr_seq[7:0], b};
        end else if (pos == 16'd2) begin
            fr_type = b;
        end else if (pos < HEADER_BYTES) begin
            fr_token = {fr_token[23:0], b};
            // A body of header only ends here with a single word and no byte.
            if (last) begin
                r = make_result(8'h00, 1'b0, 1'b1, fr_seq, fr_type, fr_token,
                                fr_len[15:0], 1'b0);
                produced = 1'b1;
            end
        end else begin
            r = make_result(b, 1'b1, last, fr_seq, fr_type, fr_token, fr_len[15:0], 1'b0);
            produced = 1'b1;
        end

        if (last) begin
            fr_phase = FR_LENGTH;
            fr_count = '0;
            fr_len   = '0;
        end else begin
            fr_count = pos + 16'd1;
        end
        return produced;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Output monitor: every accepted word is compared with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.payload_byte  = m_axis_tdata[7:0];
            got.seq_number    = m_axis_tdata[23:8];
            got.packet_type   = m_axis_tdata[31:24];
            got.session_token = m_axis_tdata[63:32];
            got.body_length   = m_axis_tdata[79:64];
            got.has_byte      = m_axis_tuser[0];
            got.bad_length    = m_axis_tuser[1];
            got.is_last       = m_axis_tlast;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h/%b/%b", m_axis_tdata,
                                          m_axis_tuser, m_axis_tlast));
            end else begin
                want = pending_results.pop_front();
                if (got.payload_byte !== want.payload_byte)
                    report_mismatch($sformatf("payload_byte %h, expected %h",
                                              got.payload_byte, want.payload_byte));
                if (got.has_byte !== want.has_byte)
                    report_mismatch($sformatf("has_byte %b, expected %b",
                                              got.has_byte, want.has_byte));
                if (got.is_last !== want.is_last)
                    report_mismatch($sformatf("is_last %b, expected %b",
                                              got.is_last, want.is_last));
                if (got.seq_number !== want.seq_number)
                    report_mismatch($sformatf("seq_number %h, expected %h",
                                              got.seq_number, want.seq_number));
                if (got.packet_type !== want.packet_type)
                    report_mismatch($sformatf("packet_type %h, expected %h",
                                              got.packet_type, want.packet_type));
                if (got.session_token !== want.session_token)
                    report_mismatch($sformatf("session_token %h, expected %h",
                                              got.session_token, want.session_token));
                if (got.body_length !== want.body_length)
                    report_mismatch($sformatf("body_length %h, expected %h",
                                              got.body_length, want.body_length));
                if (got.bad_length !== want.bad_length)
                    report_mismatch($sformatf("bad_length %b, expected %b",
                                              got.bad_length, want.bad_length));
            end
        end
    end

    // Receiver back-pressure. After each random hold time a new mode is picked:
    // always ready, coin flip, mostly stalled, or a rotating 16-bit pattern.
    int          rx_mode = 0;
    int          rx_hold = 0;
    logic [15:0] rx_mask = 16'hFFFF;
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_mask <= $urandom;
            rx_hold <= $urandom_range(50, 300);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= rx_mask[cycle_count % 16];
        endcase
    end

    // Sends one stream word. The sender runs in bursts; at the start of a burst
    // it may drop tvalid for a random gap. Returns at the accepting edge.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 32);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        burst_left--;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Holds the sender off until every owed word has come out, then lets the
    // pipeline settle, since a byte in flight may produce no word at all.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        max_len = v;
    endtask

    // Appends one packet, a bad length field, or a few noise bytes to the stream.
    // Most packets are well formed with small payloads; a few use the full
    // configured maximum or larger payloads.
    task automatic queue_packet();
        int          r;
        int          hi;
        int          pay;
        logic [31:0] len;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 6)) stream_bytes.push_back($urandom);
            return;
        end
        if (r < 20) begin
            case ($urandom_range(0, 2))
                0: len = $urandom_range(0, HEADER_BYTES - 1);
                1: len = (max_len == LENGTH_LIMIT) ? 32'h10000 + $urandom_range(0, 255)
                                                   : {16'h0000, max_len} + 32'd1
                                                     + $urandom_range(0, 3);
                default: len = $urandom;
            endcase
        end else begin
            // Below the header size every length is rejected anyway; the body
            // bytes then act as noise for the length parser.
            hi = (max_len >= HEADER_BYTES) ? int'(max_len) - HEADER_BYTES : 40;
            if ($urandom_range(0, 19) == 0 && hi <= 400)
                pay = hi;
            else if ($urandom_range(0, 9) == 0)
                pay = $urandom_range(0, (hi < 400) ? hi : 400);
            else
                pay = $urandom_range(0, (hi < 24) ? hi : 24);
            len = HEADER_BYTES + pay;
        end
        stream_bytes.push_back(len[31:24]);
        stream_bytes.push_back(len[23:16]);
        stream_bytes.push_back(len[15:8]);
        stream_bytes.push_back(len[7:0]);
        if (r >= 20) begin
            repeat (len) stream_bytes.push_back($urandom);
        end
    endtask

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL length_prefixed_packet_deframer");
        $finish;
    end

    initial begin
        t_stim_row   dir_rows[$];
        t_result     pred;
        logic [15:0] cfg_plan[PHASE_COUNT];
        logic [7:0]  b;
        int          budget;
        int          sent;

        // Directed table, run with the maximum at its reset value: a length of
        // all ones, a length just under the header size, a length just above
        // 16 bits, and a header-only packet whose fields are all ones.
        dir_rows = '{
            '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b1, make_result(8'h00, 1'b0, 1'b0, 16'h0, 8'h0, 32'h0,
                                       16'hFFFF, 1'b1)},
            '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h06, 1'b1, make_result(8'h00, 1'b0, 1'b0, 16'h0, 8'h0, 32'h0,
                                       16'h0006, 1'b1)},
            '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h00, 1'b1, make_result(8'h00, 1'b0, 1'b0, 16'h0, 8'h0, 32'h0,
                                       16'hFFFF, 1'b1)},
            '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
            '{8'h07, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b1, make_result(8'h00, 1'b0, 1'b1, 16'hFFFF, 8'hFF,
                                       32'hFFFF_FFFF, 16'h0007, 1'b0)}
        };

        // Maximum lengths for the random phases: the smallest legal value, zero
        // and six (every length rejected), 300 and 40, the largest, and random values.
        cfg_plan = '{16'd7, 16'd0, 16'd300, 16'd6, 16'hFFFF, 16'd0, 16'd40, 16'd0,
                     16'hFFFF};
        cfg_plan[5] = $urandom_range(7, 65535);
        cfg_plan[7] = $urandom_range(0, 65535);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            push_byte(dir_rows[i].data);
            if (deframe_byte(dir_rows[i].data, pred) && !dir_rows[i].has_want)
                pending_results.push_back(pred);
            if (dir_rows[i].has_want)
                pending_results.push_back(dir_rows[i].want);
        end

        // Random phases. The stream carries over from one phase to the next, so
        // a new maximum may land in the middle of an accepted packet.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_results();
            write_max_length(cfg_plan[ph]);
            budget = (cfg_plan[ph] < HEADER_BYTES) ? 60 : 260;
            sent = 0;
            while (sent < budget) begin
                if (stream_bytes.size() == 0) queue_packet();
                b = stream_bytes.pop_front();
                push_byte(b);
                if (deframe_byte(b, pred)) pending_results.push_back(pred);
                sent++;
            end
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("PASS length_prefixed_packet_deframer");
        end else begin
            $display("FAIL length_prefixed_packet_deframer");
        end
        $finish;
    end

endmodule
